[hdl/plq_pkg.sv]
// plq_pkg: types and constants shared by the price level order queue.
// Holds the request and response payloads, operation codes, controller
// states and the command and status bundles between controller and datapath.
`default_nettype none

package plq_pkg;

	// Fixed field widths of the request and response items
	localparam int NODE_W   = 10;
	localparam int QTY_IN_W = 32;
	localparam int VOL_W    = 42;
	localparam int CNT_W    = 11;

	// Response status codes
	localparam logic STATUS_DONE   = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Operation codes (code 3 is unused and changes nothing)
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP    = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [NODE_W-1:0]   node_index;
		logic [QTY_IN_W-1:0] quantity;
	} req_item_t;

	typedef struct packed {
		logic                status;
		logic                level_empty;
		logic [NODE_W-1:0]   head_node;
		logic [QTY_IN_W-1:0] head_quantity;
		logic [VOL_W-1:0]    volume_sum;
		logic [CNT_W-1:0]    orders_held;
	} rsp_item_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_APP_NODE,
		S_APP_LINK,
		S_READ,
		S_UNLINK,
		S_HEAD_QTY,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic app_node;
		logic app_link;
		logic unlink;
		logic hq_load;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic nonempty;
		logic head_read;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[hdl/plq_ram.sv]
// plq_ram: generic single write port, single read port RAM.
// Read data is registered; no reset on the array. No dependencies.
`default_nettype none

module plq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hdl/plq_ctrl.sv]
// plq_ctrl: sequencing state machine of the price level order queue.
// Depends on plq_pkg for the state, command and status types.
`default_nettype none

module plq_ctrl import plq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	input  wire status_t status,
	output logic         req_ready,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (status.op)
						OP_APPEND: state_d = S_APP_NODE;
						OP_REMOVE, OP_POP: state_d = status.nonempty ? S_READ : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_APP_NODE: state_d = S_APP_LINK;
			S_APP_LINK: state_d = S_DONE;
			S_READ:     state_d = S_UNLINK;
			S_UNLINK:   state_d = status.head_read ? S_HEAD_QTY : S_DONE;
			S_HEAD_QTY: state_d = S_DONE;
			S_DONE: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_APP_NODE: cmd.app_node = 1'b1;
			S_APP_LINK: cmd.app_link = 1'b1;
			S_READ:     ;
			S_UNLINK:   cmd.unlink = 1'b1;
			S_HEAD_QTY: cmd.hq_load = 1'b1;
			S_DONE:     cmd.out_load = status.out_free;
			default:    ;
		endcase
	end

endmodule

`default_nettype wire

[hdl/plq_datapath.sv]
// plq_datapath: link and quantity memories, list registers and result register.
// Depends on plq_pkg and plq_ram; driven by commands from plq_ctrl.
`default_nettype none

module plq_datapath import plq_pkg::*; #(
	parameter int POOL_NODES = 1024,
	parameter int QTY_BITS   = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t req,
	input  wire cmd_t      cmd,
	input  wire logic      rsp_ready,
	output status_t        status,
	output logic           rsp_valid,
	output rsp_item_t      rsp
);

	localparam int SLOT_W = $clog2(POOL_NODES);
	localparam int LINK_W = SLOT_W + 1;
	// Top bit set means no neighbour
	localparam logic [LINK_W-1:0] NO_LINK = {1'b1, {SLOT_W{1'b0}}};

	// Fold a request index into the pool by restoring subtraction of P << k
	function automatic logic [SLOT_W-1:0] fold_slot(input logic [NODE_W-1:0] raw);
		logic [NODE_W-1:0] r;
		r = raw;
		for (int k = NODE_W - 1; k >= 0; k--) begin
			if ((POOL_NODES << k) < (1 << NODE_W)) begin
				if (r >= NODE_W'(POOL_NODES << k)) begin
					r = r - NODE_W'(POOL_NODES << k);
				end
			end
		end
		return SLOT_W'(r);
	endfunction

	// Captured request
	logic [1:0]          op_q;
	logic [SLOT_W-1:0]   n_q;
	logic [QTY_BITS-1:0] qty_q;
	logic                reject_q;

	// List state
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic                nonempty_q;
	logic [VOL_W-1:0]    vol_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [QTY_BITS-1:0] hq_q;

	// Result register
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	// Memory ports
	logic                nx_we, pv_we, qt_we;
	logic [SLOT_W-1:0]   nx_waddr, pv_waddr;
	logic [LINK_W-1:0]   nx_wdata, pv_wdata;
	logic [LINK_W-1:0]   nx_rd, pv_rd;
	logic [QTY_BITS-1:0] qt_rd;
	logic [SLOT_W-1:0]   addr_a;
	logic [SLOT_W-1:0]   qt_raddr;

	// Decoded link and list conditions
	logic              nx_none, pv_none;
	logic [SLOT_W-1:0] nx_slot, pv_slot;
	logic              head_eq_tail, head_is_n, tail_is_n, unlink_head;

	assign addr_a   = (op_q == OP_POP) ? head_q : n_q;
	assign nx_none  = nx_rd[SLOT_W];
	assign pv_none  = pv_rd[SLOT_W];
	assign nx_slot  = nx_rd[SLOT_W-1:0];
	assign pv_slot  = pv_rd[SLOT_W-1:0];
	assign qt_raddr = cmd.unlink ? nx_slot : addr_a;

	assign head_eq_tail = (head_q == tail_q);
	assign head_is_n    = (head_q == n_q);
	assign tail_is_n    = (tail_q == n_q);
	assign unlink_head  = !head_eq_tail && ((op_q == OP_POP) || head_is_n);

	// Memory write selection
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = n_q;
		nx_wdata = NO_LINK;
		pv_we    = 1'b0;
		pv_waddr = n_q;
		pv_wdata = NO_LINK;
		qt_we    = 1'b0;
		if (cmd.app_node) begin
			nx_we    = 1'b1;
			pv_we    = 1'b1;
			pv_wdata = nonempty_q ? {1'b0, tail_q} : NO_LINK;
			qt_we    = 1'b1;
		end
		if (cmd.app_link && nonempty_q) begin
			nx_we    = 1'b1;
			nx_waddr = tail_q;
			nx_wdata = {1'b0, n_q};
		end
		if (cmd.unlink && !head_eq_tail) begin
			if (unlink_head) begin
				pv_we    = !nx_none;
				pv_waddr = nx_slot;
			end else if (tail_is_n) begin
				nx_we    = !pv_none;
				nx_waddr = pv_slot;
			end else begin
				// middle node: bridge the neighbours that exist
				nx_we    = !pv_none;
				nx_waddr = pv_slot;
				nx_wdata = nx_rd;
				pv_we    = !nx_none;
				pv_waddr = nx_slot;
				pv_wdata = pv_rd;
			end
		end
	end

	plq_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (addr_a),
		.rdata (nx_rd)
	);

	plq_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (addr_a),
		.rdata (pv_rd)
	);

	plq_ram #(.WIDTH(QTY_BITS), .DEPTH(POOL_NODES)) u_qty_ram (
		.clk   (clk),
		.we    (qt_we),
		.waddr (n_q),
		.wdata (qty_q),
		.raddr (qt_raddr),
		.rdata (qt_rd)
	);

	// List control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			nonempty_q  <= 1'b0;
			vol_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.app_link) begin
				if (!nonempty_q) begin
					head_q <= n_q;
				end
				tail_q     <= n_q;
				nonempty_q <= 1'b1;
				vol_q      <= vol_q + VOL_W'(qty_q);
				cnt_q      <= cnt_q + CNT_W'(1);
			end
			if (cmd.unlink) begin
				vol_q <= vol_q - VOL_W'(qt_rd);
				cnt_q <= cnt_q - CNT_W'(1);
				if (head_eq_tail ||
						(unlink_head && nx_none) ||
						(!unlink_head && tail_is_n && pv_none)) begin
					nonempty_q <= 1'b0;
					head_q     <= '0;
					tail_q     <= '0;
				end else if (unlink_head) begin
					head_q <= nx_slot;
				end else if (tail_is_n) begin
					tail_q <= pv_slot;
				end
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.operation;
			n_q      <= fold_slot(req.node_index);
			qty_q    <= QTY_BITS'(req.quantity);
			reject_q <= (op_t'(req.operation) inside {OP_REMOVE, OP_POP}) && !nonempty_q;
		end
		// head quantity follows the slot at the head
		if (cmd.app_link && (!nonempty_q || head_is_n)) begin
			hq_q <= qty_q;
		end
		if (cmd.hq_load) begin
			hq_q <= qt_rd;
		end
		if (cmd.out_load) begin
			rsp_q.status        <= reject_q ? STATUS_REJECT : STATUS_DONE;
			rsp_q.level_empty   <= !nonempty_q;
			rsp_q.head_node     <= nonempty_q ? NODE_W'(head_q) : '0;
			rsp_q.head_quantity <= nonempty_q ? QTY_IN_W'(hq_q) : '0;
			rsp_q.volume_sum    <= vol_q;
			rsp_q.orders_held   <= cnt_q;
		end
	end

	// Status to the controller
	assign status.op        = op_t'(req.operation);
	assign status.nonempty  = nonempty_q;
	assign status.head_read = cmd.unlink && unlink_head && !nx_none;
	assign status.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[hdl/price_level_order_queue.sv]
// price_level_order_queue: top level joining plq_ctrl and plq_datapath.
// Depends on plq_pkg, plq_ctrl, plq_datapath and plq_ram.
//
// One price level's orders kept as a doubly linked FIFO over POOL_NODES node
// slots held in three registered-read RAMs (next link, previous link,
// quantity). Each request appends a node at the tail, removes a given node or
// pops the head, and yields one response with the head, its quantity, the
// total volume and the order count. Remove and pop on an empty level respond
// with the reject status and change nothing. One request is handled at a
// time: a reject or an unused operation code goes straight to the response,
// an append writes the node and then links it, a removal reads the links of
// the node and unlinks it, and a pop or a removal of the head then also reads
// the quantity of the new head. The response register lets the next request
// in while a response waits. Node slots need no clearing after reset as long
// as a slot is only read once appended, which the user, not the block, ensures.
`default_nettype none

module price_level_order_queue import plq_pkg::*; #(
	parameter int POOL_NODES = 1024,
	parameter int QTY_BITS   = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	cmd_t    cmd;
	status_t status;

	plq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.status    (status),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	plq_datapath #(
		.POOL_NODES (POOL_NODES),
		.QTY_BITS   (QTY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[hdl/plq_checker.sv]
// plq_checker: port level checks for price_level_order_queue, bound to the top.
// Depends on plq_pkg for the payload types and status codes.
`default_nettype none

module plq_checker import plq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire req_item_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_item_t rsp
);

	// One request at a time: busy right after a transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// An empty level reports neither head slot nor head quantity
	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.level_empty |-> rsp.head_node == '0 && rsp.head_quantity == '0)
		else $error("empty level shows a head");

	// A rejection only happens on an empty level, which stays empty
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_REJECT |-> rsp.level_empty)
		else $error("reject reported on a non-empty level");

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

endmodule

bind price_level_order_queue plq_checker u_plq_checker (.*);

`default_nettype wire
